>>> rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared definitions for the positional list store
// Sizes, command codes and the per-request control word that the decoder
// sends to every cell of the entry chain.
// ----------------------------------------------------------------------------
package pls_pkg;

  // Store geometry.
  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Request field widths.
  localparam int CMD_BITS = 2;
  localparam int POS_BITS = 6;

  // Stream word widths, padded to whole bytes.
  localparam int IN_RAW_BITS   = CMD_BITS + POS_BITS + VALUE_BITS;
  localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = 1 + VALUE_BITS + COUNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  // Position code that names the tail entry.
  localparam logic [POS_BITS-1:0] POS_TAIL = '1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Control word broadcast to every cell in the cycle a request is taken.
  typedef struct packed {
    logic                 ins;   // accepted insert
    logic                 rem;   // accepted remove
    logic [SLOT_BITS-1:0] slot;  // target entry
  } cell_ctrl_t;

endpackage

>>> rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell: one entry of the store
// Holds one value word. On an insert it takes the new word at the target or
// its lower neighbor's above it; on a remove at or below it, its upper one's.
// ----------------------------------------------------------------------------
module pls_cell (
  input  logic                            clk,
  input  pls_pkg::cell_ctrl_t             ctrl,
  input  logic [pls_pkg::SLOT_BITS-1:0]   cell_idx,
  input  logic [pls_pkg::VALUE_BITS-1:0]  new_val,
  input  logic [pls_pkg::VALUE_BITS-1:0]  lower_val,
  input  logic [pls_pkg::VALUE_BITS-1:0]  upper_val,
  output logic [pls_pkg::VALUE_BITS-1:0]  entry_val
);

  logic [pls_pkg::VALUE_BITS-1:0] entry_r;
  logic [pls_pkg::VALUE_BITS-1:0] entry_nxt;

  // Pick the source of this entry for the next cycle.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins && (cell_idx > ctrl.slot)) begin
      entry_nxt = lower_val;
    end else if (ctrl.ins && (cell_idx == ctrl.slot)) begin
      entry_nxt = new_val;
    end else if (ctrl.rem && (cell_idx >= ctrl.slot)) begin
      entry_nxt = upper_val;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_val = entry_r;

endmodule

>>> rtl/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl: request decoder and entry counter
// Checks each request against the current length, picks the target entry
// and keeps the number of entries held.
// ----------------------------------------------------------------------------
module pls_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  logic [pls_pkg::CMD_BITS-1:0]    command,
  input  logic [pls_pkg::POS_BITS-1:0]    position,
  output pls_pkg::cell_ctrl_t             ctrl,
  output logic                            refused,
  output logic                            read_hit,
  output logic [pls_pkg::COUNT_BITS-1:0]  count_after
);

  logic [pls_pkg::COUNT_BITS-1:0] count_r;
  logic [pls_pkg::COUNT_BITS-1:0] count_nxt;
  logic                           pos_tail;
  logic                           pos_neg;
  logic [pls_pkg::POS_BITS:0]     pos_ext;
  logic [pls_pkg::POS_BITS:0]     count_ext;
  logic                           ins_ok;
  logic                           acc_ok;
  logic [pls_pkg::COUNT_BITS-1:0] last_idx;
  logic                           is_ins;
  logic                           is_read;
  logic                           is_rem;

  assign pos_tail  = (position == pls_pkg::POS_TAIL);
  assign pos_neg   = position[pls_pkg::POS_BITS-1];
  assign pos_ext   = {1'b0, position};
  assign count_ext = (pls_pkg::POS_BITS + 1)'(count_r);
  assign last_idx  = count_r - pls_pkg::COUNT_BITS'(1);

  assign is_ins  = (pls_pkg::cmd_t'(command) == pls_pkg::CMD_INSERT);
  assign is_read = (pls_pkg::cmd_t'(command) == pls_pkg::CMD_READ);
  assign is_rem  = (pls_pkg::cmd_t'(command) == pls_pkg::CMD_REMOVE);

  // Range checks against the current length.
  assign ins_ok = (count_r < pls_pkg::COUNT_BITS'(pls_pkg::CAPACITY)) &&
                  (pos_tail || (!pos_neg && (pos_ext <= count_ext)));
  assign acc_ok = (count_r != '0) &&
                  (pos_tail || (!pos_neg && (pos_ext < count_ext)));

  // Target entry: the tail maps to the append slot or the last entry.
  always_comb begin
    ctrl.ins  = take && is_ins && ins_ok;
    ctrl.rem  = take && is_rem && acc_ok;
    if (is_ins) begin
      ctrl.slot = pos_tail ? count_r[pls_pkg::SLOT_BITS-1:0]
                           : position[pls_pkg::SLOT_BITS-1:0];
    end else begin
      ctrl.slot = pos_tail ? last_idx[pls_pkg::SLOT_BITS-1:0]
                           : position[pls_pkg::SLOT_BITS-1:0];
    end
  end

  assign read_hit = is_read && acc_ok;
  assign refused  = !((is_ins && ins_ok) || ((is_read || is_rem) && acc_ok));

  // Length after the request.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + pls_pkg::COUNT_BITS'(1);
    end else if (ctrl.rem) begin
      count_nxt = last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_after = count_nxt;

endmodule

>>> rtl/positional_list_store_top.sv
// ----------------------------------------------------------------------------
// positional_list_store_top: bounded ordered list with positional access
// Streaming front end around a chain of entry cells and a request decoder.
// ----------------------------------------------------------------------------
// Each request inserts, reads or removes one entry at a position counted from
// the head; position -1 names the tail, and an insert at the current length
// appends. Every request returns one result with a status, the value read
// and the new length; a refused request leaves the store unchanged. A request
// is decoded and applied in the cycle it is accepted, with all cells shifting
// in parallel, and its result appears on the output register in the next cycle.
// The block takes one request per cycle: a new request is accepted whenever
// the output register is empty or its result is being taken in that cycle.
module positional_list_store_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] command, [7:2] position, [39:8] value
  input  logic [pls_pkg::IN_DATA_BITS-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] status, [32:1] read_value, [37:33] entry_count, upper bits zero
  output logic [pls_pkg::OUT_DATA_BITS-1:0]   out_tdata
);

  localparam int POS_LO = pls_pkg::CMD_BITS;
  localparam int VAL_LO = pls_pkg::CMD_BITS + pls_pkg::POS_BITS;

  logic                                   take;
  logic [pls_pkg::CMD_BITS-1:0]           command;
  logic [pls_pkg::POS_BITS-1:0]           position;
  logic [pls_pkg::VALUE_BITS-1:0]         value;
  pls_pkg::cell_ctrl_t                    ctrl;
  logic                                   refused;
  logic                                   read_hit;
  logic [pls_pkg::COUNT_BITS-1:0]         count_after;
  logic [pls_pkg::VALUE_BITS-1:0]         entry_val [pls_pkg::CAPACITY];
  logic [pls_pkg::VALUE_BITS-1:0]         lower_val [pls_pkg::CAPACITY];
  logic [pls_pkg::VALUE_BITS-1:0]         upper_val [pls_pkg::CAPACITY];
  logic [pls_pkg::VALUE_BITS-1:0]         read_val;
  logic                                   out_valid_r;
  logic                                   out_valid_nxt;
  logic [pls_pkg::OUT_DATA_BITS-1:0]      out_data_r;
  logic [pls_pkg::OUT_DATA_BITS-1:0]      out_data_nxt;

  // Handshake and field unpacking.
  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;
  assign command   = in_tdata[pls_pkg::CMD_BITS-1:0];
  assign position  = in_tdata[POS_LO +: pls_pkg::POS_BITS];
  assign value     = in_tdata[VAL_LO +: pls_pkg::VALUE_BITS];

  pls_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .command     (command),
    .position    (position),
    .ctrl        (ctrl),
    .refused     (refused),
    .read_hit    (read_hit),
    .count_after (count_after)
  );

  // Chain of entry cells; the ends feed back their own word.
  for (genvar g = 0; g < pls_pkg::CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign lower_val[g] = entry_val[g];
    end else begin : g_inner_lo
      assign lower_val[g] = entry_val[g-1];
    end
    if (g == pls_pkg::CAPACITY - 1) begin : g_tail
      assign upper_val[g] = entry_val[g];
    end else begin : g_inner_hi
      assign upper_val[g] = entry_val[g+1];
    end

    pls_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (pls_pkg::SLOT_BITS'(g)),
      .new_val   (value),
      .lower_val (lower_val[g]),
      .upper_val (upper_val[g]),
      .entry_val (entry_val[g])
    );
  end

  // Read port: the entry at the target slot, zero unless the read succeeds.
  assign read_val = read_hit ? entry_val[ctrl.slot] : '0;

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pls_pkg::OUT_DATA_BITS'({count_after, read_val, refused});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> dv/tb_positional_list_store_top.sv
// ----------------------------------------------------------------------------
// tb_positional_list_store_top: self-checking bench for the positional store
// Drives insert, read and remove requests through the input stream, keeps its
// own copy of the list to work out each answer, and compares every returned
// result field by field. Both stream sides idle at random, but for phases with a gapless sender.
// ----------------------------------------------------------------------------
module tb_positional_list_store_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  // Field offsets inside the stream words.
  localparam int POS_LSB   = pls_pkg::CMD_BITS;
  localparam int VAL_LSB   = pls_pkg::CMD_BITS + pls_pkg::POS_BITS;
  localparam int RD_LSB    = 1;
  localparam int COUNT_LSB = 1 + pls_pkg::VALUE_BITS;

  typedef struct packed {
    logic                           status;
    logic [pls_pkg::VALUE_BITS-1:0] read_value;
    logic [pls_pkg::COUNT_BITS-1:0] entry_count;
  } list_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_EVERY_THIRD,
    STALL_LONG
  } stall_mode_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [pls_pkg::IN_DATA_BITS-1:0]  in_tdata   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [pls_pkg::OUT_DATA_BITS-1:0] out_tdata;

  // Predicted contents of the store.
  logic [pls_pkg::VALUE_BITS-1:0] stored_words [pls_pkg::CAPACITY];
  int                             stored_count = 0;

  list_result_t expected_results [$];
  int           error_count  = 0;
  int           quiet_cycles = 0;

  // Sender burst control.
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // Receiver stall pattern state.
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_left  = 0;
  int          hold_left   = 0;
  bit          hold_level  = 1'b0;

  positional_list_store_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one request to the predicted list and return the answer it gives.
  function automatic list_result_t apply_list_request(
      pls_pkg::cmd_t cmd,
      logic [pls_pkg::POS_BITS-1:0] pos_code,
      logic [pls_pkg::VALUE_BITS-1:0] val);
    list_result_t res;
    int           pos;
    int           slot;
    int           i;
    res.status     = 1'b1;
    res.read_value = '0;
    pos = int'($signed(pos_code));
    case (cmd) inside
      pls_pkg::CMD_INSERT: begin
        if (stored_count < pls_pkg::CAPACITY && pos >= -1 && pos <= stored_count) begin
          slot = (pos == -1) ? stored_count : pos;
          for (i = stored_count; i > slot; i--) stored_words[i] = stored_words[i-1];
          stored_words[slot] = val;
          stored_count++;
          res.status = 1'b0;
        end
      end
      pls_pkg::CMD_READ, pls_pkg::CMD_REMOVE: begin
        if (stored_count > 0 && pos >= -1 && pos < stored_count) begin
          slot = (pos == -1) ? stored_count - 1 : pos;
          if (cmd == pls_pkg::CMD_READ) begin
            res.read_value = stored_words[slot];
          end else begin
            for (i = slot; i + 1 < stored_count; i++) stored_words[i] = stored_words[i+1];
            stored_count--;
          end
          res.status = 1'b0;
        end
      end
      default: ;
    endcase
    res.entry_count = pls_pkg::COUNT_BITS'(stored_count);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Send one request; the answer is predicted at the edge where it is taken.
  task automatic send_request(input pls_pkg::cmd_t cmd,
                              input logic [pls_pkg::POS_BITS-1:0] pos_code,
                              input logic [pls_pkg::VALUE_BITS-1:0] val);
    logic [pls_pkg::IN_DATA_BITS-1:0] word;
    logic                             ready_seen;
    int                               gap;
    word = '0;
    word[pls_pkg::CMD_BITS-1:0]              = cmd;
    word[POS_LSB +: pls_pkg::POS_BITS]       = pos_code;
    word[VAL_LSB +: pls_pkg::VALUE_BITS]     = val;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    expected_results.push_back(apply_list_request(cmd, pos_code, val));
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic wait_for_results();
    if (expected_results.size() != 0) in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Random value that now and then takes one of the extremes.
  function automatic logic [pls_pkg::VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Position mostly in or just past the legal range, sometimes any code.
  function automatic logic [pls_pkg::POS_BITS-1:0] pick_position(int last_valid);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return pls_pkg::POS_BITS'($urandom_range(0, 63));
    if (r < 27 || last_valid < 0) return pls_pkg::POS_BITS'(-1);
    if (r < 35) return pls_pkg::POS_BITS'(last_valid + 1);
    if (r < 45) return pls_pkg::POS_BITS'(last_valid);
    if (r < 52) return '0;
    return pls_pkg::POS_BITS'($urandom_range(0, last_valid));
  endfunction

  // Edge positions and every refusal reachable without filling the store.
  task automatic test_directed_edges();
    // Empty store: tail and range refusals.
    send_request(pls_pkg::CMD_READ,   pls_pkg::POS_BITS'(-1), '0);
    send_request(pls_pkg::CMD_REMOVE, pls_pkg::POS_BITS'(-1), '1);
    send_request(pls_pkg::CMD_REMOVE, pls_pkg::POS_BITS'(0),  '0);
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(1),  32'h1234_5678);
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(-2), 32'h1234_5678);
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(-32), 32'h1234_5678);
    // Append on empty, then remove the sole entry.
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(-1), '0);
    send_request(pls_pkg::CMD_REMOVE, pls_pkg::POS_BITS'(0),  '0);
    // Build head, tail, middle and append-at-length inserts, then one past the length.
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(0),  '1);
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(-1), 32'h0000_0001);
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(1),  32'h8000_0000);
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(3),  32'h5A5A_5A5A);
    send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(5),  32'hA5A5_A5A5);
    // Reads in range, at the length and at the far codes.
    send_request(pls_pkg::CMD_READ,   pls_pkg::POS_BITS'(0),  '1);
    send_request(pls_pkg::CMD_READ,   pls_pkg::POS_BITS'(-1), '0);
    send_request(pls_pkg::CMD_READ,   pls_pkg::POS_BITS'(2),  '0);
    send_request(pls_pkg::CMD_READ,   pls_pkg::POS_BITS'(4),  '0);
    send_request(pls_pkg::CMD_READ,   pls_pkg::POS_BITS'(31), '0);
    send_request(pls_pkg::CMD_READ,   pls_pkg::POS_BITS'(-2), '0);
    // The unused command must change nothing.
    send_request(pls_pkg::CMD_UNUSED, pls_pkg::POS_BITS'(0),  '1);
    send_request(pls_pkg::CMD_REMOVE, pls_pkg::POS_BITS'(-1), '0);
    send_request(pls_pkg::CMD_REMOVE, pls_pkg::POS_BITS'(1),  '0);
    send_request(pls_pkg::CMD_READ,   pls_pkg::POS_BITS'(1),  '0);
    send_request(pls_pkg::CMD_REMOVE, pls_pkg::POS_BITS'(2),  '0);
  endtask

  // Fill to capacity, probe the full store, then drain to empty.
  task automatic test_fill_and_drain(input int rounds);
    int round;
    int n;
    for (round = 0; round < rounds; round++) begin
      // The first round runs the sender without gaps.
      gaps_on = (round != 0);
      while (stored_count < pls_pkg::CAPACITY) begin
        send_request(pls_pkg::CMD_INSERT,
                     pls_pkg::POS_BITS'($urandom_range(0, stored_count + 1) - 1),
                     pick_value());
      end
      send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(-1), pick_value());
      send_request(pls_pkg::CMD_INSERT, pls_pkg::POS_BITS'(pls_pkg::CAPACITY),
                   pick_value());
      send_request(pls_pkg::CMD_INSERT,
                   pls_pkg::POS_BITS'($urandom_range(0, pls_pkg::CAPACITY)), pick_value());
      send_request(pls_pkg::CMD_READ, pls_pkg::POS_BITS'(pls_pkg::CAPACITY - 1),
                   pick_value());
      send_request(pls_pkg::CMD_READ, pls_pkg::POS_BITS'(pls_pkg::CAPACITY), pick_value());
      for (n = 0; n < 3; n++) begin
        send_request(pls_pkg::CMD_READ,
                     pls_pkg::POS_BITS'($urandom_range(0, pls_pkg::CAPACITY) - 1),
                     pick_value());
      end
      while (stored_count > 0) begin
        if ($urandom_range(0, 3) == 0) begin
          send_request(pls_pkg::CMD_READ, pick_position(stored_count - 1), pick_value());
        end
        send_request(pls_pkg::CMD_REMOVE,
                     pls_pkg::POS_BITS'($urandom_range(0, stored_count) - 1),
                     pick_value());
      end
      send_request(pls_pkg::CMD_REMOVE, pls_pkg::POS_BITS'(-1), pick_value());
      send_request(pls_pkg::CMD_READ, pls_pkg::POS_BITS'(0), pick_value());
      if (round == 1) wait_for_results();
    end
    gaps_on = 1'b1;
  endtask

  // Random mix whose insert/remove bias swings so the length sweeps its range.
  task automatic test_random_mix(input int total);
    int            sent;
    int            phase_left;
    bit            fill_bias;
    int            r;
    pls_pkg::cmd_t cmd;
    sent       = 0;
    phase_left = 0;
    fill_bias  = 1'b1;
    while (sent < total) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 160);
        fill_bias  = ~fill_bias;
        gaps_on    = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 2) == 0) wait_for_results();
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 5) cmd = pls_pkg::CMD_UNUSED;
      else if (r < 20) cmd = pls_pkg::CMD_READ;
      else if (r < (fill_bias ? 75 : 40)) cmd = pls_pkg::CMD_INSERT;
      else cmd = pls_pkg::CMD_REMOVE;
      case (cmd)
        pls_pkg::CMD_INSERT:
          send_request(cmd, pick_position(stored_count), pick_value());
        pls_pkg::CMD_UNUSED:
          send_request(cmd, pls_pkg::POS_BITS'($urandom_range(0, 63)), pick_value());
        default:
          send_request(cmd, pick_position(stored_count - 1), pick_value());
      endcase
      sent++;
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: ready follows a stall mode that is redrawn at random whenever its run ends.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:        out_tready <= 1'b1;
      STALL_COIN:        out_tready <= 1'($urandom_range(0, 1));
      STALL_EVERY_THIRD: out_tready <= (stall_left % 3 == 0);
      default: begin
        if (hold_left == 0) begin
          hold_level = ~hold_level;
          hold_left  = hold_level ? $urandom_range(1, 8) : $urandom_range(1, 30);
        end else begin
          hold_left--;
        end
        out_tready <= hold_level;
      end
    endcase
  end

  // Compare each result taken at the coming edge with the oldest prediction.
  always @(negedge clk) begin : check_results
    list_result_t want;
    list_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status      = out_tdata[0];
      got.read_value  = out_tdata[RD_LSB +: pls_pkg::VALUE_BITS];
      got.entry_count = out_tdata[COUNT_LSB +: pls_pkg::COUNT_BITS];
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending: tdata=%h", out_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %b want %b", got.status, want.status));
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %h want %h",
                                    got.read_value, want.read_value));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    got.entry_count, want.entry_count));
        if (out_tdata[pls_pkg::OUT_DATA_BITS-1:pls_pkg::OUT_RAW_BITS] !== '0)
          report_mismatch($sformatf("padding bits not zero: tdata=%h", out_tdata));
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results pending", expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    wait_for_results();
    test_fill_and_drain(4);
    wait_for_results();
    test_random_mix(1400);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/pls_ctrl.sv
rtl/positional_list_store_top.sv
dv/tb_positional_list_store_top.sv
